[hw/rtl/iirf_pkg.sv]
// Shared types and constants for the direct-form-I IIR filter.
package iirf_pkg;

  // Coefficient format: signed Q4.16
  localparam int COEF_W    = 20;
  localparam int COEF_REGS = 3;
  localparam logic signed [COEF_W-1:0] COEF_ONE = 20'sd65536;

  // Sample width on the item channels
  localparam int IO_W = 16;

  // APB side
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_ZERO0 = 3'd0,
    REG_ZERO1 = 3'd1,
    REG_ZERO2 = 3'd2,
    REG_POLE0 = 3'd3,
    REG_POLE1 = 3'd4,
    REG_POLE2 = 3'd5
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SETUP,
    ST_DIV,
    ST_FINISH
  } state_t;

endpackage

[hw/rtl/iirf_if.sv]
// Item channel interfaces for the IIR filter input and result streams.
interface iirf_in_if import iirf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirf_out_if import iirf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IO_W-1:0] sample_out;
  logic                   clipped;
  logic                   invalid;

  modport source (output valid, output sample_out, output clipped, output invalid,
                  input ready);
  modport sink   (input valid, input sample_out, input clipped, input invalid,
                  output ready);
endinterface

[hw/rtl/iirf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module iirf_div import iirf_pkg::*; #(
  parameter int DVD_W = 38,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // One shift-subtract step
  assign rem_sh = {rem_r[DVS_W-1:0], quo_r[DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

  // Divider signals done only after a running division, never while idle
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

endmodule

[hw/rtl/iir_direct_form_filter.sv]
// Top level: direct-form-I IIR filter with APB coefficient registers.
//
// Usage:
//   in_if  (sink)   : one signed sample per item, valid/ready handshake.
//   out_if (source) : one result item per input item: saturated sample,
//                     clipped flag and sticky invalid flag.
//   APB port        : six 20-bit Q4.16 coefficients at byte address 4*i
//                     (zero_coef_0..2, pole_coef_0..2); write only when idle.
// Timing: one item at a time. An item passes through multiply-accumulate
//   on one shared multiplier over the active taps (NT = number of active
//   taps, 5 for a biquad), a setup state, the divide state, which builds the
//   quotient bit by bit and ends on the divider's done strobe, and a finish
//   state that writes the result once the output register is free.
//   A zero pole_coef_0, or an invalid flag already set, skips the divide.
// Reset (synchronous, rst_n low): histories and invalid flag cleared,
//   coefficients back to the unity pass-through filter, no result pending.
// Stall: the result sits in an output register; the next item is accepted
//   while it waits, but its result is held until the register is taken.
module iir_direct_form_filter import iirf_pkg::*; #(
  parameter int ZERO_TAPS   = 3,
  parameter int POLE_TAPS   = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  iirf_in_if.sink               in_if,
  iirf_out_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SB     = SAMPLE_BITS;
  // Taps past the register file have zero coefficients and are dropped
  localparam int NZ     = (ZERO_TAPS < COEF_REGS) ? ZERO_TAPS : COEF_REGS;
  localparam int NP     = (POLE_TAPS < COEF_REGS) ? POLE_TAPS : COEF_REGS;
  localparam int NZH    = (NZ > 1) ? NZ - 1 : 1;
  localparam int NPH    = (NP > 1) ? NP - 1 : 1;
  localparam int NT     = NZ + NP - 1;
  localparam int CNT_W  = $clog2(NT + 1);
  localparam int PROD_W = COEF_W + SB;
  localparam int ACC_W  = COEF_W + SB + 3;
  localparam int DVD_W  = ACC_W - 1;
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(64'd1 << (SB - 1));
  localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] zc_r [COEF_REGS];
  logic signed [COEF_W-1:0] pc_r [COEF_REGS];
  logic signed [SB-1:0]     xh_r [NZH];
  logic signed [SB-1:0]     yh_r [NPH];

  logic signed [SB-1:0]     x_r, x_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     psub_r, psub_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     neg_r, neg_nxt;
  logic                     inv_r, inv_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [IO_W-1:0]   out_sample_r, out_sample_nxt;
  logic                     out_clip_r, out_clip_nxt;
  logic                     out_inv_r, out_inv_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic                     div_start;
  logic                     div_done;
  logic [DVD_W-1:0]         div_quo;
  logic [DVD_W-1:0]         acc_mag;
  logic [COEF_W-1:0]        pc0_mag;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [SB-1:0]     op_sel;
  logic                     sub_sel;
  logic                     q_over;
  logic signed [SB-1:0]     q_val;
  logic signed [SB-1:0]     y_fin;
  logic                     clip_fin;
  logic                     cfg_wr;
  reg_idx_t                 cfg_idx;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zc_r[0] <= COEF_ONE;
      zc_r[1] <= '0;
      zc_r[2] <= '0;
      pc_r[0] <= COEF_ONE;
      pc_r[1] <= '0;
      pc_r[2] <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ZERO0: zc_r[0] <= pwdata[COEF_W-1:0];
        REG_ZERO1: zc_r[1] <= pwdata[COEF_W-1:0];
        REG_ZERO2: zc_r[2] <= pwdata[COEF_W-1:0];
        REG_POLE0: pc_r[0] <= pwdata[COEF_W-1:0];
        REG_POLE1: pc_r[1] <= pwdata[COEF_W-1:0];
        REG_POLE2: pc_r[2] <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Readback, sign-extended
  always_comb begin
    unique case (cfg_idx)
      REG_ZERO0: prdata = CFG_DATA_W'(zc_r[0]);
      REG_ZERO1: prdata = CFG_DATA_W'(zc_r[1]);
      REG_ZERO2: prdata = CFG_DATA_W'(zc_r[2]);
      REG_POLE0: prdata = CFG_DATA_W'(pc_r[0]);
      REG_POLE1: prdata = CFG_DATA_W'(pc_r[1]);
      REG_POLE2: prdata = CFG_DATA_W'(pc_r[2]);
      default:   prdata = '0;
    endcase
  end

  // ---------------- sequencer ----------------
  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;
  assign inv_nxt  = (state_r == ST_SETUP) ? (inv_r || (pc_r[0] == '0)) : inv_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_MAC;
      ST_MAC:    if (cnt_r == CNT_W'(NT)) state_nxt = ST_SETUP;
      ST_SETUP:  state_nxt = inv_nxt ? ST_FINISH : ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_r == ST_IDLE);
    div_start   = (state_r == ST_SETUP) && !inv_nxt;
  end

  // Tap select for the shared multiplier
  always_comb begin
    coef_sel = '0;
    op_sel   = '0;
    sub_sel  = 1'b0;
    for (int k = 0; k < NT; k++) begin
      if (cnt_r == CNT_W'(k)) begin
        if (k < NZ) begin
          coef_sel = zc_r[(k < NZ) ? k : 0];
          op_sel   = (k == 0) ? x_r : xh_r[(k > 0 && k < NZ) ? k - 1 : 0];
        end else begin
          coef_sel = pc_r[(k >= NZ) ? k - NZ + 1 : 0];
          op_sel   = yh_r[(k >= NZ) ? k - NZ : 0];
          sub_sel  = 1'b1;
        end
      end
    end
  end

  // Magnitudes for the divider
  assign acc_mag = acc_r[ACC_W-1] ? DVD_W'(-acc_r) : DVD_W'(acc_r);
  assign pc0_mag = pc_r[0][COEF_W-1] ? COEF_W'(-pc_r[0]) : COEF_W'(pc_r[0]);

  // Quotient sign and saturation
  assign q_over   = neg_r ? (div_quo > NEG_LIM) : (div_quo > POS_LIM);
  assign q_val    = neg_r ? -$signed(div_quo[SB-1:0]) : $signed(div_quo[SB-1:0]);
  assign y_fin    = inv_r ? '0 : (q_over ? (neg_r ? SMIN : SMAX) : q_val);
  assign clip_fin = !inv_r && q_over;

  // Datapath next values
  always_comb begin
    x_nxt          = x_r;
    cnt_nxt        = cnt_r;
    prod_nxt       = prod_r;
    psub_nxt       = psub_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_sample_nxt = out_sample_r;
    out_clip_nxt   = out_clip_r;
    out_inv_nxt    = out_inv_r;
    unique case (state_r)
      ST_IDLE: begin
        x_nxt   = $signed(SB'($unsigned(in_if.sample_in)));
        cnt_nxt = '0;
        acc_nxt = '0;
      end
      ST_MAC: begin
        cnt_nxt  = cnt_r + CNT_W'(1);
        prod_nxt = coef_sel * op_sel;
        psub_nxt = sub_sel;
        if (cnt_r != '0) begin
          acc_nxt = psub_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end
      end
      ST_SETUP: begin
        neg_nxt = acc_r[ACC_W-1] ^ pc_r[0][COEF_W-1];
      end
      ST_DIV: ;
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = IO_W'(y_fin);
          out_clip_nxt   = clip_fin;
          out_inv_nxt    = inv_r;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      inv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      inv_r       <= inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    prod_r       <= prod_nxt;
    psub_r       <= psub_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    out_sample_r <= out_sample_nxt;
    out_clip_r   <= out_clip_nxt;
    out_inv_r    <= out_inv_nxt;
  end

  // Sample histories, shifted when a result is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NZH; k++) xh_r[k] <= '0;
      for (int k = 0; k < NPH; k++) yh_r[k] <= '0;
    end else if (state_r == ST_FINISH && out_free) begin
      for (int k = NZH - 1; k > 0; k--) xh_r[k] <= xh_r[k-1];
      for (int k = NPH - 1; k > 0; k--) yh_r[k] <= yh_r[k-1];
      xh_r[0] <= x_r;
      yh_r[0] <= y_fin;
    end
  end

  // Divider: accumulator magnitude by pole_coef_0 magnitude
  iirf_div #(
    .DVD_W (DVD_W),
    .DVS_W (COEF_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (pc0_mag),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.sample_out = out_sample_r;
  assign out_if.clipped    = out_clip_r;
  assign out_if.invalid    = out_inv_r;

  // ---------------- assertions ----------------
  a_inv_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(inv_r))
    else $error("invalid flag cleared without reset");

  a_inv_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.invalid |-> out_if.sample_out == '0 && !out_if.clipped)
    else $error("invalid result carries data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_if.ready)
    else $error("second item accepted while busy");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

endmodule
